[rtl/core/per_destination_median_collector_defines.svh]
// Assertion macros for the median collector RTL.
// Depends on nothing; included by per_destination_median_collector.sv.
`ifndef PER_DESTINATION_MEDIAN_COLLECTOR_DEFINES_SVH
`define PER_DESTINATION_MEDIAN_COLLECTOR_DEFINES_SVH
// Assert that cond implies res in the same cycle, checked outside reset.
`define PDMC_ASSERT_IMPL(label, clk_s, rst_s, cond, res) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (cond) |-> (res)) \
    else $error("assertion failed");
// Assert that cond implies res in the next cycle.
`define PDMC_ASSERT_NEXT(label, clk_s, rst_s, cond, res) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (cond) |=> (res)) \
    else $error("assertion failed");
`endif

[rtl/core/pdmc_pkg.sv]
// Package for the median collector: sizes, status codes, state encoding.
// Depends on nothing.
package pdmc_pkg;
  localparam int MaxDest    = 16;
  localparam int MaxPending = 4;
  localparam int MaxSamples = 32;
  localparam int DoneDepth  = 16;
  localparam int DestW  = 4;
  localparam int SlotW  = 2;
  localparam int SampW  = 5;
  localparam int CntW   = 6;
  localparam int DoneW  = 4;
  localparam int StoreAw = SlotW + DestW + SampW;
  localparam int CntAw   = SlotW + DestW;

  localparam logic [2:0] StAccepted  = 3'd0;
  localparam logic [2:0] StDropFull  = 3'd1;
  localparam logic [2:0] StDropDone  = 3'd2;
  localparam logic [2:0] StMedian    = 3'd3;
  localparam logic [2:0] StIgnored   = 3'd4;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_REC   = 8'b0000_0010,
    S_CLR   = 8'b0000_0100,
    S_LOAD  = 8'b0000_1000,
    S_SORT  = 8'b0001_0000,
    S_EMIT  = 8'b0010_0000,
    S_OUT   = 8'b0100_0000,
    S_FREE  = 8'b1000_0000
  } state_t;

  typedef struct packed {
    logic [2:0]       status;
    logic [DestW-1:0] dest;
    logic [63:0]      median;
    logic             last;
  } result_t;
endpackage

[rtl/core/pdmc_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read.
// Depends on nothing.
module pdmc_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

[rtl/core/pdmc_rank.sv]
// Rank-based selection of the upper median over a buffer of up to 32 samples.
// Depends on pdmc_pkg. One candidate is compared against one sample per cycle.
module pdmc_rank import pdmc_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [CntW-1:0]  n,
  input  logic [63:0]      wval,
  input  logic             wen,
  input  logic [SampW-1:0] widx,
  output logic             done,
  output logic [63:0]      median
);
  // Candidate i is the median when less(i) <= n/2 < less(i)+equal(i).
  // Count samples ordered before the candidate (ties broken by index) so exactly one index has rank n/2.
  logic [63:0]      buf_q [MaxSamples];
  logic [SampW-1:0] ci, cj;
  logic [CntW-1:0]  rank;
  logic             busy;
  logic [63:0]      cand;
  logic             before_j;

  assign cand = buf_q[ci];
  assign before_j = (buf_q[cj] < cand) || (buf_q[cj] == cand && cj < ci);

  always_ff @(posedge clk) begin
    if (wen) buf_q[widx] <= wval;
  end

  // done stays high until reset or a start with nonzero n
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      if (start) begin
        busy <= (n != '0);
        done <= (n == '0);
        median <= '0;
        ci <= '0;
        cj <= '0;
        rank <= '0;
      end else if (busy) begin
        if ({1'b0, cj} == n - 1'b1) begin
          if ((rank + CntW'(before_j)) == (n >> 1)) begin
            median <= cand;
            busy <= 1'b0;
            done <= 1'b1;
          end
          cj <= '0;
          rank <= '0;
          ci <= ci + 1'b1;
        end else begin
          rank <= rank + CntW'(before_j);
          cj <= cj + 1'b1;
        end
      end
    end
  end
endmodule

[rtl/core/pdmc_tags.sv]
// Pending-slot and completed-tag tables with their match logic.
// Depends on pdmc_pkg.
module pdmc_tags import pdmc_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic [63:0]      tag,
  output logic             is_done,
  output logic             pend_hit,
  output logic [SlotW-1:0] pend_slot,
  output logic             free_any,
  output logic [SlotW-1:0] free_slot,
  input  logic             alloc,
  input  logic [SlotW-1:0] alloc_slot,
  input  logic             retire,
  input  logic [SlotW-1:0] retire_slot
);
  logic [63:0]       ptag [MaxPending];
  logic [MaxPending-1:0] pvalid;
  logic [63:0]       dtag [DoneDepth];
  logic [DoneDepth-1:0]  dvalid;
  logic [DoneW-1:0]  dptr;

  always_comb begin
    is_done = 1'b0;
    for (int i = 0; i < DoneDepth; i++)
      if (dvalid[i] && dtag[i] == tag) is_done = 1'b1;
    pend_hit = 1'b0;
    pend_slot = '0;
    for (int i = MaxPending - 1; i >= 0; i--)
      if (pvalid[i] && ptag[i] == tag) begin
        pend_hit = 1'b1;
        pend_slot = SlotW'(i);
      end
    free_any = 1'b0;
    free_slot = '0;
    for (int i = MaxPending - 1; i >= 0; i--)
      if (!pvalid[i]) begin
        free_any = 1'b1;
        free_slot = SlotW'(i);
      end
  end

  always_ff @(posedge clk) begin
    if (alloc) ptag[alloc_slot] <= tag;
    if (retire) dtag[dptr] <= tag;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pvalid <= '0;
      dvalid <= '0;
      dptr <= '0;
    end else begin
      if (alloc) pvalid[alloc_slot] <= 1'b1;
      if (retire) begin
        pvalid[retire_slot] <= 1'b0;
        dvalid[dptr] <= 1'b1;
        dptr <= dptr + 1'b1;
      end
    end
  end
endmodule

[rtl/core/per_destination_median_collector.sv]
// Usage:
// Items enter on s_axis (tdata: req_type, interval_tag, destination,
// duration) and results leave on m_axis (tdata: status, result_destination,
// median, last as tlast). A record item does a tag lookup and issues the count
// read from the count RAM, then the sample write; a new slot first clears its
// 16 counts. Dropped records and ignored completions go straight to output.
// A completion walks every reported destination: its n samples are copied
// from the sample RAM into a 32-entry buffer and the median is found by
// ranking, one compare per cycle with the single comparator, and emitted.
// Then the counts of the slot are cleared.
// One item is processed at a time; s_axis_tready is low while busy.
// Reset clears the pending and completed valid bits and the done pointer;
// allocating a slot clears its 16 counts with a pass through the count RAM.
// When the receiver stalls, the result register holds, one more result
// waits in a staging register and the block waits.
// dest_count at address 0 via APB; 0 acts as 1, above 16 saturates.
`include "per_destination_median_collector_defines.svh"
module per_destination_median_collector import pdmc_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [135:0] s_axis_tdata, // req_type, interval_tag, destination, duration, pad
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [71:0]  m_axis_tdata, // status, result_destination, median, pad
  output logic         m_axis_tlast,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);
  localparam logic [2:0] RegDestCount = 3'd0;

  state_t state;
  logic [4:0]  dest_count;
  logic [63:0] tag, dur;
  logic [63:0] tag_q;
  logic [DestW-1:0] dest;
  logic [SlotW-1:0] slot;
  logic [DestW-1:0] di;
  logic [DestW:0]   nrep;
  logic [CntW:0]    li;
  logic [CntW-1:0]  cnt;
  logic [CntW-1:0]  rec_cnt;
  logic        clr_new;
  logic        is_done, pend_hit, free_any, alloc, retire;
  logic [SlotW-1:0] pend_slot, free_slot;
  logic        cnt_we;
  logic [CntAw-1:0] cnt_wa, cnt_ra;
  logic [CntW-1:0]  cnt_wd, cnt_rd;
  logic        st_we;
  logic [StoreAw-1:0] st_wa, st_ra;
  logic [63:0] st_rd;
  logic        rk_start, rk_done, rk_wen;
  logic [63:0] rk_med;
  result_t     res;
  result_t     res_stage;
  logic        ovalid;
  logic        step;
  logic        out_load;

  assign pready = 1'b1;
  assign prdata = (paddr == RegDestCount) ? {27'd0, dest_count} : 32'd0;
  always_ff @(posedge clk) begin
    if (rst) dest_count <= 5'd16;
    else if (psel && penable && pwrite && paddr == RegDestCount)
      dest_count <= pwdata[4:0];
  end

  always_comb begin
    if (dest_count == 5'd0) nrep = 5'd1;
    else if (dest_count > 5'd16) nrep = 5'd16;
    else nrep = dest_count;
  end

  pdmc_tags u_tags (
    .clk, .rst, .tag, .is_done, .pend_hit, .pend_slot, .free_any, .free_slot,
    .alloc, .alloc_slot(free_slot), .retire, .retire_slot(slot)
  );

  pdmc_ram #(.Width(CntW), .Depth(MaxPending * MaxDest)) u_cnt (
    .clk, .we(cnt_we), .waddr(cnt_wa), .wdata(cnt_wd), .raddr(cnt_ra), .rdata(cnt_rd)
  );
  pdmc_ram #(.Width(64), .Depth(MaxPending * MaxDest * MaxSamples)) u_store (
    .clk, .we(st_we), .waddr(st_wa), .wdata(dur), .raddr(st_ra), .rdata(st_rd)
  );

  // sample li-2 arrives from the store at LOAD step li
  assign rk_wen = (state == S_LOAD) && li >= 7'd2 && (li - 7'd2) < {1'b0, cnt};
  assign rk_start = (state == S_LOAD) && li >= 7'd2 && (li - 7'd2) >= {1'b0, cnt};
  pdmc_rank u_rank (
    .clk, .rst, .start(rk_start), .n(cnt), .wval(st_rd), .wen(rk_wen),
    .widx(SampW'(li - 7'd2)), .done(rk_done), .median(rk_med)
  );

  assign s_axis_tready = (state == S_IDLE);
  assign alloc  = (state == S_IDLE) && s_axis_tvalid && !s_axis_tdata[0] &&
                  !is_done && !pend_hit && free_any;
  assign retire = (state == S_FREE) && di == DestW'(MaxDest - 1);
  assign step = !ovalid || m_axis_tready;
  assign out_load = step && ((state == S_SORT && rk_done) || state == S_OUT);

  assign cnt_ra = (state == S_IDLE) ?
                  {(pend_hit ? pend_slot : free_slot), s_axis_tdata[68:65]} : {slot, di};
  assign st_ra  = {slot, di, SampW'(li - 7'd1)};
  // a fresh slot has just been cleared, so its count is zero
  assign rec_cnt = clr_new ? '0 : cnt_rd;
  assign st_wa  = {slot, dest, rec_cnt[SampW-1:0]};
  assign tag = (state == S_IDLE) ? s_axis_tdata[64:1] : tag_q;

  always_comb begin
    cnt_we = 1'b0;
    cnt_wa = {slot, di};
    cnt_wd = '0;
    st_we = 1'b0;
    if (state == S_CLR || state == S_FREE) cnt_we = 1'b1;
    if (state == S_REC && rec_cnt < CntW'(MaxSamples)) begin
      cnt_we = 1'b1;
      cnt_wa = {slot, dest};
      cnt_wd = rec_cnt + 1'b1;
      st_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) ovalid <= 1'b0;
    else if (out_load) ovalid <= 1'b1;
    else if (m_axis_tready) ovalid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: if (s_axis_tvalid) begin
          tag_q <= s_axis_tdata[64:1];
          dest <= s_axis_tdata[68:65];
          dur <= s_axis_tdata[132:69];
          slot <= pend_hit ? pend_slot : free_slot;
          di <= '0;
          clr_new <= !pend_hit;
          if (!s_axis_tdata[0]) begin
            if (is_done) begin
              res_stage <= '{StDropDone, s_axis_tdata[68:65], 64'd0, 1'b1};
              state <= S_OUT;
            end else if (!pend_hit && !free_any) begin
              res_stage <= '{StDropFull, s_axis_tdata[68:65], 64'd0, 1'b1};
              state <= S_OUT;
            end else if (!pend_hit) state <= S_CLR;
            else state <= S_REC;
          end else begin
            if (is_done || !pend_hit) begin
              res_stage <= '{StIgnored, '0, 64'd0, 1'b1};
              state <= S_OUT;
            end else begin
              li <= '0;
              state <= S_LOAD;
            end
          end
        end
        S_CLR: begin
          di <= di + 1'b1;
          if (di == DestW'(MaxDest - 1)) state <= S_REC;
        end
        S_REC: begin
          // count RAM read of {slot,dest} issued in IDLE; after a clear it is 0
          res_stage <= '{(rec_cnt < CntW'(MaxSamples)) ? StAccepted : StDropFull,
                         dest, 64'd0, 1'b1};
          state <= S_OUT;
        end
        S_LOAD: begin
          li <= li + 1'b1;
          if (rk_start) state <= S_SORT;
        end
        S_SORT: if (rk_done && step) begin
          res <= '{StMedian, di, rk_med, ({1'b0, di} == nrep - 1'b1)};
          state <= S_EMIT;
        end
        S_EMIT: begin
          li <= '0;
          if ({1'b0, di} == nrep - 1'b1) begin
            di <= '0;
            state <= S_FREE;
          end else begin
            di <= di + 1'b1;
            state <= S_LOAD;
          end
        end
        S_OUT: if (step) begin
          res <= res_stage;
          state <= S_IDLE;
        end
        S_FREE: begin
          di <= di + 1'b1;
          if (di == DestW'(MaxDest - 1)) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // load path holds the count read at the start of LOAD for this destination
  always_ff @(posedge clk) begin
    if (state == S_LOAD && li == 7'd1) cnt <= cnt_rd;
  end

  assign m_axis_tvalid = ovalid;
  assign m_axis_tdata = {1'b0, res.median, res.dest, res.status};
  assign m_axis_tlast = res.last;

  `PDMC_ASSERT_NEXT(a_out_hold, clk, rst, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
  `PDMC_ASSERT_IMPL(a_ready_idle, clk, rst, s_axis_tready, state == S_IDLE)
  `PDMC_ASSERT_IMPL(a_one_retire, clk, rst, retire, !alloc)
endmodule
